// ===== rtl/dtm_pkg.sv =====
// Shared types, codes and a helper function of the debounced threshold monitor.
package dtm_pkg;

  // Qualified level codes
  localparam logic [2:0] LV_NORMAL = 3'd0;
  localparam logic [2:0] LV_LNC    = 3'd1;
  localparam logic [2:0] LV_LCR    = 3'd2;
  localparam logic [2:0] LV_UNC    = 3'd3;
  localparam logic [2:0] LV_UCR    = 3'd4;

  // Raised flag codes
  localparam logic [1:0] RAISE_NONE = 2'd0;
  localparam logic [1:0] RAISE_UCR  = 2'd1;
  localparam logic [1:0] RAISE_UNC  = 2'd2;
  localparam logic [1:0] RAISE_LCR  = 2'd3;

  // Flag bit positions
  localparam int F_LNC = 0;
  localparam int F_LCR = 1;
  localparam int F_UNC = 2;
  localparam int F_UCR = 3;

  // Debounce counter slots
  localparam int C_UCR = 0;
  localparam int C_UNC = 1;
  localparam int C_LCR = 2;
  localparam int C_LNC = 3;

  // Sensor kinds
  localparam logic [1:0] KIND_OVERTEMP = 2'd1;
  localparam logic [1:0] KIND_FAN      = 2'd2;

  // Configuration register indexes
  localparam logic CFG_RETRY_LIMIT    = 1'b0;
  localparam logic CFG_FAN_FAIL_LIMIT = 1'b1;

  localparam logic [3:0] RETRY_LIMIT_RESET    = 4'd10;
  localparam logic [3:0] FAN_FAIL_LIMIT_RESET = 4'd2;
  localparam logic [3:0] FAN_COUNT_MAX        = 4'd15;

  // Threshold hits of one sample
  typedef struct packed {
    logic hu;
    logic hn;
    logic hl;
    logic hm;
  } hits_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic [3:0] sensor_id;
    logic       in_range;
    logic [1:0] sensor_kind;
    logic       last_in_pass;
    hits_t      hits;
  } item_t;

  typedef logic [3:0][3:0] cnt_t;

  // Per-sensor stored state
  typedef struct packed {
    cnt_t       cnt;
    logic [3:0] flags;
  } entry_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] val;
  } bump_t;

  // Advance one debounce counter against the retry limit
  function automatic bump_t bump(input logic [3:0] c, input logic [3:0] lim);
    logic [4:0] n;
    bump_t      r;
    n = {1'b0, c} + 5'd1;
    r.hit = (n >= {1'b0, lim});
    r.val = r.hit ? lim : n[3:0];
    return r;
  endfunction

endpackage

// ===== rtl/dtm_classify.sv =====
// Front end: compare a sample with its four thresholds and tag the request.
module dtm_classify #(
  parameter int NUM_SENSORS = 16
) (
  input  logic               [3:0]  sensor_id,
  input  logic               [1:0]  sensor_kind,
  input  logic signed        [31:0] sample_value,
  input  logic signed        [31:0] upper_critical,
  input  logic signed        [31:0] upper_noncritical,
  input  logic signed        [31:0] lower_critical,
  input  logic signed        [31:0] lower_noncritical,
  input  logic                      last_in_pass,
  output dtm_pkg::item_t            item
);

  // Compare against each enabled threshold
  always_comb begin
    item.sensor_id    = sensor_id;
    item.in_range     = (32'(sensor_id) < NUM_SENSORS);
    item.sensor_kind  = sensor_kind;
    item.last_in_pass = last_in_pass;
    item.hits.hu = (upper_critical != 32'sd0) && (sample_value >= upper_critical);
    item.hits.hn = (upper_noncritical != 32'sd0) && (sample_value >= upper_noncritical);
    item.hits.hl = (lower_critical != 32'sd0) && (sample_value <= lower_critical);
    item.hits.hm = (lower_noncritical != 32'sd0) && (sample_value <= lower_noncritical);
  end

endmodule

// ===== rtl/dtm_queue.sv =====
// Two-entry queue of classified requests between front and back.
module dtm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dtm_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           ready_out,
  output dtm_pkg::item_t pop_item
);

  dtm_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full      = (count == 2'd2);
  assign ready_out = (count != 2'd0);
  assign pop_item  = slots[rd_ptr];

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/dtm_back.sv =====
// Back end: per-sensor debounce state, flag update, pass requests and result register.
module dtm_back #(
  parameter int NUM_SENSORS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [3:0]     retry_limit,
  input  logic [3:0]     fan_fail_limit,
  input  logic           q_ready,
  input  dtm_pkg::item_t q_item,
  output logic           q_pop,
  output logic           result_valid,
  input  logic           result_stall,
  output logic [2:0]     level,
  output logic [1:0]     raised,
  output logic [3:0]     cleared_mask,
  output logic [3:0]     fail_flags,
  output logic           archive_request,
  output logic           shutdown_request,
  output logic           pass_done
);

  localparam int AW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  dtm_pkg::entry_t mem [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] entry_ok;

  logic            ex_valid;
  dtm_pkg::item_t  ex_item;
  dtm_pkg::entry_t ex_state;
  logic            ex_adv;
  logic [AW-1:0]   ex_addr;
  logic [AW-1:0]   q_addr;
  logic            fwd;

  logic [3:0]      fan_fail_count;
  logic [1:0]      pass_requests;

  dtm_pkg::entry_t state_next;
  logic [2:0]      level_next;
  logic [1:0]      raised_next;
  logic [3:0]      cleared_next;
  logic [3:0]      fan_fail_count_next;
  logic [1:0]      pass_requests_next;
  logic [1:0]      pass_out;

  assign ex_adv  = ex_valid && (!result_valid || !result_stall);
  assign q_pop   = q_ready && (!ex_valid || ex_adv);
  assign ex_addr = AW'(ex_item.sensor_id);
  assign q_addr  = AW'(q_item.sensor_id);
  assign fwd     = ex_adv && ex_item.in_range && (ex_addr == q_addr);

  // Debounce, flag update and pass accounting for the request in execute
  always_comb begin
    dtm_pkg::bump_t b_ucr;
    dtm_pkg::bump_t b_unc;
    dtm_pkg::bump_t b_lcr;
    dtm_pkg::bump_t b_lnc;
    dtm_pkg::cnt_t  c;
    logic [3:0]     f;
    logic [2:0]     lv;
    b_ucr = dtm_pkg::bump(ex_state.cnt[dtm_pkg::C_UCR], retry_limit);
    b_unc = dtm_pkg::bump(ex_state.cnt[dtm_pkg::C_UNC], retry_limit);
    b_lcr = dtm_pkg::bump(ex_state.cnt[dtm_pkg::C_LCR], retry_limit);
    b_lnc = dtm_pkg::bump(ex_state.cnt[dtm_pkg::C_LNC], retry_limit);
    c     = ex_state.cnt;
    f     = ex_state.flags;
    lv    = dtm_pkg::LV_NORMAL;
    raised_next         = dtm_pkg::RAISE_NONE;
    cleared_next        = 4'd0;
    fan_fail_count_next = fan_fail_count;
    pass_requests_next  = pass_requests;

    // Qualify the level, upper side first
    if (ex_item.hits.hu) begin
      c[dtm_pkg::C_UCR] = b_ucr.val;
      if (b_ucr.hit) begin
        lv = dtm_pkg::LV_UCR;
      end else if (ex_item.hits.hn) begin
        c[dtm_pkg::C_UNC] = b_unc.val;
        if (b_unc.hit) begin
          lv = dtm_pkg::LV_UNC;
        end
      end
    end else if (ex_item.hits.hn) begin
      c[dtm_pkg::C_UNC] = b_unc.val;
      if (b_unc.hit) begin
        lv = dtm_pkg::LV_UNC;
      end
    end else if (ex_item.hits.hl) begin
      c[dtm_pkg::C_LCR] = b_lcr.val;
      if (b_lcr.hit) begin
        lv = dtm_pkg::LV_LCR;
      end else if (ex_item.hits.hm) begin
        c[dtm_pkg::C_LNC] = b_lnc.val;
        if (b_lnc.hit) begin
          lv = dtm_pkg::LV_LNC;
        end
      end
    end else if (ex_item.hits.hm) begin
      c[dtm_pkg::C_LNC] = b_lnc.val;
      if (b_lnc.hit) begin
        lv = dtm_pkg::LV_LNC;
      end
    end else begin
      c = '0;
    end

    // Latch, recover and raise the fail flags
    case (lv)
      dtm_pkg::LV_UCR: begin
        if (!f[dtm_pkg::F_UCR]) begin
          f[dtm_pkg::F_UCR] = 1'b1;
          raised_next = dtm_pkg::RAISE_UCR;
          if (ex_item.in_range && ex_item.sensor_kind == dtm_pkg::KIND_OVERTEMP) begin
            pass_requests_next = 2'b11;
          end
        end
      end
      dtm_pkg::LV_UNC: begin
        if (f[dtm_pkg::F_UCR]) begin
          f[dtm_pkg::F_UCR] = 1'b0;
          c[dtm_pkg::C_UCR] = 4'd0;
          cleared_next[dtm_pkg::F_UCR] = 1'b1;
        end
        if (!f[dtm_pkg::F_UNC]) begin
          f[dtm_pkg::F_UNC] = 1'b1;
          raised_next = dtm_pkg::RAISE_UNC;
          if (ex_item.in_range && ex_item.sensor_kind == dtm_pkg::KIND_OVERTEMP) begin
            pass_requests_next[0] = 1'b1;
          end
        end
      end
      dtm_pkg::LV_LCR: begin
        if (!f[dtm_pkg::F_LCR]) begin
          f[dtm_pkg::F_LCR] = 1'b1;
          raised_next = dtm_pkg::RAISE_LCR;
          if (ex_item.in_range && ex_item.sensor_kind == dtm_pkg::KIND_FAN &&
              fan_fail_count != dtm_pkg::FAN_COUNT_MAX) begin
            fan_fail_count_next = fan_fail_count + 4'd1;
          end
        end
      end
      dtm_pkg::LV_LNC: begin
        if (f[dtm_pkg::F_LCR]) begin
          f[dtm_pkg::F_LCR] = 1'b0;
          c[dtm_pkg::C_LCR] = 4'd0;
          cleared_next[dtm_pkg::F_LCR] = 1'b1;
        end
      end
      default: begin
        cleared_next = f;
        f = 4'd0;
      end
    endcase

    state_next.cnt   = c;
    state_next.flags = f;
    level_next       = lv;

    // Drop the sensor part for an unknown sensor
    if (!ex_item.in_range) begin
      level_next   = dtm_pkg::LV_NORMAL;
      raised_next  = dtm_pkg::RAISE_NONE;
      cleared_next = 4'd0;
    end

    // Apply the fan rule at the end of a pass
    pass_out = pass_requests_next;
    if (ex_item.last_in_pass && fan_fail_count_next >= fan_fail_limit) begin
      pass_out[1] = 1'b1;
    end
  end

  // Read sensor state on pop, forwarding the entry being written
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ex_item <= q_item;
      if (fwd) begin
        ex_state <= state_next;
      end else if (q_item.in_range && entry_ok[q_addr]) begin
        ex_state <= mem[q_addr];
      end else begin
        ex_state <= '0;
      end
    end
  end

  // Write back sensor state
  always_ff @(posedge clk) begin
    if (ex_adv && ex_item.in_range) begin
      mem[ex_addr] <= state_next;
    end
  end

  // Entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_ok <= '0;
    end else if (ex_adv && ex_item.in_range) begin
      entry_ok[ex_addr] <= 1'b1;
    end
  end

  // Execute stage occupancy and pass accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid       <= 1'b0;
      fan_fail_count <= 4'd0;
      pass_requests  <= 2'd0;
    end else begin
      if (q_pop) begin
        ex_valid <= 1'b1;
      end else if (ex_adv) begin
        ex_valid <= 1'b0;
      end
      if (ex_adv) begin
        if (ex_item.last_in_pass) begin
          fan_fail_count <= 4'd0;
          pass_requests  <= 2'd0;
        end else begin
          fan_fail_count <= fan_fail_count_next;
          pass_requests  <= pass_out;
        end
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ex_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (ex_adv) begin
      level            <= level_next;
      raised           <= raised_next;
      cleared_mask     <= cleared_next;
      fail_flags       <= ex_item.in_range ? state_next.flags : 4'd0;
      archive_request  <= pass_out[0];
      shutdown_request <= pass_out[1];
      pass_done        <= ex_item.last_in_pass;
    end
  end

  // Hold the execute request while the result register is blocked
  a_ex_hold: assert property (@(posedge clk) disable iff (rst)
    ex_valid && !ex_adv |=> ex_valid && $stable(ex_item))
    else $error("execute request lost while blocked");

  // The lower non-critical flag is never latched
  a_no_lnc_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !fail_flags[dtm_pkg::F_LNC])
    else $error("LNC flag latched");

  // A cleared flag is not also held
  a_clear_disjoint: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (cleared_mask & fail_flags) == 4'd0)
    else $error("flag both cleared and held");

  // A raised UNC flag matches the qualified UNC level
  a_raise_level: assert property (@(posedge clk) disable iff (rst)
    result_valid && raised == dtm_pkg::RAISE_UNC |-> level == dtm_pkg::LV_UNC)
    else $error("UNC raised without UNC level");

endmodule

// ===== rtl/debounced_threshold_monitor.sv =====
// An accepted sample passes through the queue, the execute register and the result register.
// Throughput: one sample per cycle while the result side does not stall; the per-sensor
// state read-modify-write in the back end forwards the entry being written to the next read.
// A two-entry queue takes one more sample after the result side stalls, then stalls too.
// Reset: synchronous; clears all debounce state, flags, pass requests and queues, and
// returns retry_limit to 10 and fan_fail_limit to 2.
module debounced_threshold_monitor #(
  parameter int NUM_SENSORS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic        [3:0]  cfg_data,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic        [3:0]  sensor_id,
  input  logic        [1:0]  sensor_kind,
  input  logic signed [31:0] sample_value,
  input  logic signed [31:0] upper_critical,
  input  logic signed [31:0] upper_noncritical,
  input  logic signed [31:0] lower_critical,
  input  logic signed [31:0] lower_noncritical,
  input  logic               last_in_pass,
  output logic               result_valid,
  input  logic               result_stall,
  output logic        [2:0]  level,
  output logic        [1:0]  raised,
  output logic        [3:0]  cleared_mask,
  output logic        [3:0]  fail_flags,
  output logic               archive_request,
  output logic               shutdown_request,
  output logic               pass_done
);

  logic [3:0]     retry_limit;
  logic [3:0]     fan_fail_limit;
  dtm_pkg::item_t front_item;
  dtm_pkg::item_t q_item;
  logic           q_full;
  logic           q_ready;
  logic           q_pop;
  logic           push;

  assign cfg_ready    = 1'b1;
  assign sample_stall = q_full;
  assign push         = sample_valid && !q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit    <= dtm_pkg::RETRY_LIMIT_RESET;
      fan_fail_limit <= dtm_pkg::FAN_FAIL_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dtm_pkg::CFG_RETRY_LIMIT:    retry_limit    <= cfg_data;
        dtm_pkg::CFG_FAN_FAIL_LIMIT: fan_fail_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  dtm_classify #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_classify (
    .sensor_id        (sensor_id),
    .sensor_kind      (sensor_kind),
    .sample_value     (sample_value),
    .upper_critical   (upper_critical),
    .upper_noncritical(upper_noncritical),
    .lower_critical   (lower_critical),
    .lower_noncritical(lower_noncritical),
    .last_in_pass     (last_in_pass),
    .item             (front_item)
  );

  dtm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(front_item),
    .full     (q_full),
    .pop      (q_pop),
    .ready_out(q_ready),
    .pop_item (q_item)
  );

  dtm_back #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .retry_limit     (retry_limit),
    .fan_fail_limit  (fan_fail_limit),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .level           (level),
    .raised          (raised),
    .cleared_mask    (cleared_mask),
    .fail_flags      (fail_flags),
    .archive_request (archive_request),
    .shutdown_request(shutdown_request),
    .pass_done       (pass_done)
  );

endmodule

// ===== tb/sv/threshold_alarm_checker.sv =====
`timescale 1ns / 100ps
// Watches the monitor's channels, predicts each sample's alarm status and compares the results.
module threshold_alarm_checker #(
  parameter int NUM_SENSORS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic        [3:0]  cfg_data,
  input  logic               sample_valid,
  input  logic               sample_stall,
  input  logic        [3:0]  sensor_id,
  input  logic        [1:0]  sensor_kind,
  input  logic signed [31:0] sample_value,
  input  logic signed [31:0] upper_critical,
  input  logic signed [31:0] upper_noncritical,
  input  logic signed [31:0] lower_critical,
  input  logic signed [31:0] lower_noncritical,
  input  logic               last_in_pass,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic        [2:0]  level,
  input  logic        [1:0]  raised,
  input  logic        [3:0]  cleared_mask,
  input  logic        [3:0]  fail_flags,
  input  logic               archive_request,
  input  logic               shutdown_request,
  input  logic               pass_done,
  output int unsigned        fail_count,
  output int unsigned        pending
);

  typedef struct packed {
    logic [2:0] level;
    logic [1:0] raised;
    logic [3:0] cleared;
    logic [3:0] flags;
    logic       archive;
    logic       shutdown;
    logic       done;
  } alarm_status_t;

  // Shadow of the monitor's configuration and state
  logic [3:0]       retry_lim;
  logic [3:0]       fan_lim;
  logic [3:0][3:0]  debounce_mem [NUM_SENSORS];
  logic [3:0]       flag_mem [NUM_SENSORS];
  logic [3:0]       fan_failures;
  logic             pend_archive;
  logic             pend_shutdown;
  alarm_status_t    due_status [$];

  // Advance one debounce counter; bit 4 set when the level qualifies
  function automatic logic [4:0] advance(input logic [3:0] c);
    logic [4:0] n;
    n = {1'b0, c} + 5'd1;
    if (n >= {1'b0, retry_lim}) return {1'b1, retry_lim};
    return {1'b0, n[3:0]};
  endfunction

  function automatic alarm_status_t predict_status(
    input logic        [3:0]  id,
    input logic        [1:0]  kind,
    input logic signed [31:0] v,
    input logic signed [31:0] ucr,
    input logic signed [31:0] unc,
    input logic signed [31:0] lcr,
    input logic signed [31:0] lnc,
    input logic               last
  );
    alarm_status_t   s;
    logic [3:0][3:0] cnt;
    logic [3:0]      f;
    logic [4:0]      st;
    logic            hu, hn, hl, hm;
    s = '0;
    if (id < NUM_SENSORS) begin
      cnt = debounce_mem[id];
      f = flag_mem[id];
      hu = (ucr != 32'sd0) && (v >= ucr);
      hn = (unc != 32'sd0) && (v >= unc);
      hl = (lcr != 32'sd0) && (v <= lcr);
      hm = (lnc != 32'sd0) && (v <= lnc);
      s.level = dtm_pkg::LV_NORMAL;
      // Upper levels take priority over lower ones; critical before non-critical
      if (hu) begin
        st = advance(cnt[dtm_pkg::C_UCR]);
        cnt[dtm_pkg::C_UCR] = st[3:0];
        if (st[4]) begin
          s.level = dtm_pkg::LV_UCR;
        end else if (hn) begin
          st = advance(cnt[dtm_pkg::C_UNC]);
          cnt[dtm_pkg::C_UNC] = st[3:0];
          if (st[4]) s.level = dtm_pkg::LV_UNC;
        end
      end else if (hn) begin
        st = advance(cnt[dtm_pkg::C_UNC]);
        cnt[dtm_pkg::C_UNC] = st[3:0];
        if (st[4]) s.level = dtm_pkg::LV_UNC;
      end else if (hl) begin
        st = advance(cnt[dtm_pkg::C_LCR]);
        cnt[dtm_pkg::C_LCR] = st[3:0];
        if (st[4]) begin
          s.level = dtm_pkg::LV_LCR;
        end else if (hm) begin
          st = advance(cnt[dtm_pkg::C_LNC]);
          cnt[dtm_pkg::C_LNC] = st[3:0];
          if (st[4]) s.level = dtm_pkg::LV_LNC;
        end
      end else if (hm) begin
        st = advance(cnt[dtm_pkg::C_LNC]);
        cnt[dtm_pkg::C_LNC] = st[3:0];
        if (st[4]) s.level = dtm_pkg::LV_LNC;
      end else begin
        cnt = '0;
      end
      // Latch, recover and raise the pass actions
      case (s.level)
        dtm_pkg::LV_UCR: begin
          if (!f[dtm_pkg::F_UCR]) begin
            f[dtm_pkg::F_UCR] = 1'b1;
            s.raised = dtm_pkg::RAISE_UCR;
            if (kind == dtm_pkg::KIND_OVERTEMP) begin
              pend_archive = 1'b1;
              pend_shutdown = 1'b1;
            end
          end
        end
        dtm_pkg::LV_UNC: begin
          if (f[dtm_pkg::F_UCR]) begin
            f[dtm_pkg::F_UCR] = 1'b0;
            cnt[dtm_pkg::C_UCR] = '0;
            s.cleared[dtm_pkg::F_UCR] = 1'b1;
          end
          if (!f[dtm_pkg::F_UNC]) begin
            f[dtm_pkg::F_UNC] = 1'b1;
            s.raised = dtm_pkg::RAISE_UNC;
            if (kind == dtm_pkg::KIND_OVERTEMP) pend_archive = 1'b1;
          end
        end
        dtm_pkg::LV_LCR: begin
          if (!f[dtm_pkg::F_LCR]) begin
            f[dtm_pkg::F_LCR] = 1'b1;
            s.raised = dtm_pkg::RAISE_LCR;
            if (kind == dtm_pkg::KIND_FAN && fan_failures != dtm_pkg::FAN_COUNT_MAX)
              fan_failures = fan_failures + 4'd1;
          end
        end
        dtm_pkg::LV_LNC: begin
          if (f[dtm_pkg::F_LCR]) begin
            f[dtm_pkg::F_LCR] = 1'b0;
            cnt[dtm_pkg::C_LCR] = '0;
            s.cleared[dtm_pkg::F_LCR] = 1'b1;
          end
        end
        default: begin
          s.cleared = f;
          f = '0;
        end
      endcase
      debounce_mem[id] = cnt;
      flag_mem[id] = f;
      s.flags = f;
    end
    // Fan rule closes the pass
    if (last && fan_failures >= fan_lim) pend_shutdown = 1'b1;
    s.archive = pend_archive;
    s.shutdown = pend_shutdown;
    s.done = last;
    if (last) begin
      fan_failures = '0;
      pend_archive = 1'b0;
      pend_shutdown = 1'b0;
    end
    return s;
  endfunction

  function automatic int field_bad(input string name, input int unsigned want,
                                   input int unsigned got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Track configuration, predict on each sample request, compare each result request
  always @(posedge clk) begin
    alarm_status_t want;
    int            errs;
    errs = 0;
    if (rst) begin
      retry_lim = dtm_pkg::RETRY_LIMIT_RESET;
      fan_lim = dtm_pkg::FAN_FAIL_LIMIT_RESET;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        debounce_mem[i] = '0;
        flag_mem[i] = '0;
      end
      fan_failures = '0;
      pend_archive = 1'b0;
      pend_shutdown = 1'b0;
      due_status.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dtm_pkg::CFG_RETRY_LIMIT) retry_lim = cfg_data;
        else fan_lim = cfg_data;
      end
      if (sample_valid && !sample_stall)
        due_status.push_back(predict_status(sensor_id, sensor_kind, sample_value,
                                            upper_critical, upper_noncritical,
                                            lower_critical, lower_noncritical,
                                            last_in_pass));
      if (result_valid && !result_stall) begin
        if (due_status.size() == 0) begin
          $error("result request with no sample outstanding");
          errs = 1;
        end else begin
          want = due_status.pop_front();
          errs += field_bad("level", 32'(want.level), 32'(level));
          errs += field_bad("raised", 32'(want.raised), 32'(raised));
          errs += field_bad("cleared_mask", 32'(want.cleared), 32'(cleared_mask));
          errs += field_bad("fail_flags", 32'(want.flags), 32'(fail_flags));
          errs += field_bad("archive_request", 32'(want.archive), 32'(archive_request));
          errs += field_bad("shutdown_request", 32'(want.shutdown),
                            32'(shutdown_request));
          errs += field_bad("pass_done", 32'(want.done), 32'(pass_done));
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= due_status.size();
  end

endmodule

// ===== tb/sv/debounced_threshold_monitor_tb.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the debounced threshold monitor.
module debounced_threshold_monitor_tb;

  localparam int NUM_SENSORS   = 16;
  localparam int RANDOM_ROUNDS = 8;
  localparam int ROUND_ITEMS   = 200;
  localparam int MAX_IDLE      = 13;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [1:0] KIND_GENERAL = 2'd0;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  // Fixed Q23.8 thresholds and in-band values of the directed part
  localparam logic signed [31:0] TH_UCR = 32'sd25600;
  localparam logic signed [31:0] TH_UNC = 32'sd12800;
  localparam logic signed [31:0] TH_LCR = -32'sd12800;
  localparam logic signed [31:0] TH_LNC = -32'sd5120;
  localparam logic signed [31:0] V_UCR  = 32'sd51200;
  localparam logic signed [31:0] V_UNC  = 32'sd15360;
  localparam logic signed [31:0] V_LCR  = -32'sd15360;
  localparam logic signed [31:0] V_LNC  = -32'sd7680;
  localparam logic signed [31:0] V_MAX  = 32'sh7FFFFFFF;
  localparam logic signed [31:0] V_MIN  = 32'sh80000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = 1'b0;
  logic        [3:0]  cfg_data = '0;
  logic               sample_valid = 1'b0;
  logic               sample_stall;
  logic        [3:0]  sensor_id = '0;
  logic        [1:0]  sensor_kind = '0;
  logic signed [31:0] sample_value = '0;
  logic signed [31:0] upper_critical = '0;
  logic signed [31:0] upper_noncritical = '0;
  logic signed [31:0] lower_critical = '0;
  logic signed [31:0] lower_noncritical = '0;
  logic               last_in_pass = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic        [2:0]  level;
  logic        [1:0]  raised;
  logic        [3:0]  cleared_mask;
  logic        [3:0]  fail_flags;
  logic               archive_request;
  logic               shutdown_request;
  logic               pass_done;
  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        cycle_count = 0;
  logic               quiet = 1'b0;

  // Per-sensor threshold profiles of the random part
  logic signed [31:0] prof_mid [NUM_SENSORS];
  logic signed [31:0] prof_thr [NUM_SENSORS][4];
  logic        [3:0]  prof_on [NUM_SENSORS];
  logic        [1:0]  prof_kind [NUM_SENSORS];
  int                 prof_band [NUM_SENSORS];
  int                 id_base = 0;

  debounced_threshold_monitor #(.NUM_SENSORS(NUM_SENSORS)) dut (.*);

  threshold_alarm_checker #(.NUM_SENSORS(NUM_SENSORS)) u_checker (.*);

  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int idle_cycles();
    return quiet ? 0 : $urandom_range(MAX_IDLE, 0);
  endfunction

  // Hold each sample request until the monitor takes it
  task automatic send_sample(input logic [3:0] id, input logic [1:0] kind,
                             input logic signed [31:0] v, input logic signed [31:0] ucr,
                             input logic signed [31:0] unc, input logic signed [31:0] lcr,
                             input logic signed [31:0] lnc, input logic last);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sensor_id <= id;
    sensor_kind <= kind;
    sample_value <= v;
    upper_critical <= ucr;
    upper_noncritical <= unc;
    lower_critical <= lcr;
    lower_noncritical <= lnc;
    last_in_pass <= last;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic send_banded(input logic [3:0] id, input logic [1:0] kind,
                             input logic signed [31:0] v, input logic last);
    send_sample(id, kind, v, TH_UCR, TH_UNC, TH_LCR, TH_LNC, last);
  endtask

  // Write both limits, back to back
  task automatic set_limits(input logic [3:0] retry, input logic [3:0] fan);
    cfg_valid <= 1'b1;
    cfg_index <= dtm_pkg::CFG_RETRY_LIMIT;
    cfg_data <= retry;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= dtm_pkg::CFG_FAN_FAIL_LIMIT;
    cfg_data <= fan;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop the sample request and wait for every outstanding result
  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Ordered thresholds around a random midpoint, a few levels disabled
  task automatic new_profile(input int id);
    int mid;
    mid = $urandom_range(2097152, 0) - 1048576;
    prof_mid[id] = mid;
    prof_thr[id][dtm_pkg::C_LNC] = mid - $urandom_range(4096, 1);
    prof_thr[id][dtm_pkg::C_LCR] = prof_thr[id][dtm_pkg::C_LNC] - $urandom_range(4096, 1);
    prof_thr[id][dtm_pkg::C_UNC] = mid + $urandom_range(4096, 1);
    prof_thr[id][dtm_pkg::C_UCR] = prof_thr[id][dtm_pkg::C_UNC] + $urandom_range(4096, 1);
    for (int k = 0; k < 4; k++) prof_on[id][k] = ($urandom_range(7, 0) != 0);
    prof_kind[id] = 2'($urandom_range(3, 0));
    prof_band[id] = 0;
  endtask

  // Mostly runs of samples held in one band per sensor; a little raw noise
  task automatic send_random_sample();
    int                 id;
    int                 span;
    logic signed [31:0] v;
    logic signed [31:0] thr [4];
    if ($urandom_range(99, 0) < 8) begin
      send_sample(4'($urandom), 2'($urandom), $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom_range(7, 0) == 0);
    end else begin
      if ($urandom_range(3, 0) == 0) id = $urandom_range(NUM_SENSORS - 1, 0);
      else id = (id_base + $urandom_range(3, 0)) % NUM_SENSORS;
      if ($urandom_range(63, 0) == 0) new_profile(id);
      if ($urandom_range(99, 0) < 7) prof_band[id] = $urandom_range(4, 0);
      case (prof_band[id])
        1: begin
          span = prof_thr[id][dtm_pkg::C_LNC] - prof_thr[id][dtm_pkg::C_LCR] - 1;
          v = prof_thr[id][dtm_pkg::C_LNC] - $urandom_range(span, 0);
        end
        2: v = prof_thr[id][dtm_pkg::C_LCR] - $urandom_range(4095, 0);
        3: begin
          span = prof_thr[id][dtm_pkg::C_UCR] - prof_thr[id][dtm_pkg::C_UNC] - 1;
          v = prof_thr[id][dtm_pkg::C_UNC] + $urandom_range(span, 0);
        end
        4: v = prof_thr[id][dtm_pkg::C_UCR] + $urandom_range(4095, 0);
        default: v = prof_mid[id];
      endcase
      for (int k = 0; k < 4; k++) thr[k] = prof_on[id][k] ? prof_thr[id][k] : 32'sd0;
      send_sample(4'(id), prof_kind[id], v, thr[dtm_pkg::C_UCR], thr[dtm_pkg::C_UNC],
                  thr[dtm_pkg::C_LCR], thr[dtm_pkg::C_LNC], $urandom_range(7, 0) == 0);
    end
  endtask

  // Stall the result side for a random hold before each result request
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      hold = idle_cycles();
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  initial begin
    int         round;
    logic [3:0] retry;
    logic [3:0] fan;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Immediate qualification: raise, recover and clear every level
    set_limits(4'd1, 4'd1);
    send_banded(4'd0, dtm_pkg::KIND_OVERTEMP, V_MAX, 1'b0);
    send_banded(4'd0, dtm_pkg::KIND_OVERTEMP, V_UNC, 1'b0);
    send_banded(4'd0, dtm_pkg::KIND_OVERTEMP, 32'sd0, 1'b1);
    send_banded(4'd1, dtm_pkg::KIND_FAN, V_LCR, 1'b0);
    send_banded(4'd1, dtm_pkg::KIND_FAN, V_LNC, 1'b0);
    send_sample(4'd2, dtm_pkg::KIND_FAN, V_MIN, TH_UCR, TH_UNC, V_MIN, 32'sd0, 1'b1);
    send_sample(4'd15, KIND_SPARE, V_MAX, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_sample(4'd15, KIND_SPARE, V_MIN, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_sample(4'd3, KIND_GENERAL, V_MAX, V_MAX, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_sample(4'd4, dtm_pkg::KIND_OVERTEMP, TH_UNC, 32'sd0, TH_UNC, TH_LCR, TH_LNC,
                1'b1);

    // Zero limits: qualify at once, shut down at every pass end
    drain();
    set_limits(4'd0, 4'd0);
    send_banded(4'd6, dtm_pkg::KIND_FAN, V_LCR, 1'b1);
    send_banded(4'd7, KIND_GENERAL, 32'sd0, 1'b1);

    // Build counters under a high limit, then lower it
    drain();
    set_limits(4'd15, 4'd15);
    repeat (5) send_banded(4'd8, dtm_pkg::KIND_OVERTEMP, V_UCR, 1'b0);
    drain();
    set_limits(4'd2, 4'd2);
    send_banded(4'd8, dtm_pkg::KIND_OVERTEMP, V_UCR, 1'b1);
    repeat (2) send_banded(4'd9, dtm_pkg::KIND_OVERTEMP, V_UCR, 1'b0);
    send_banded(4'd10, dtm_pkg::KIND_OVERTEMP, V_UNC, 1'b0);
    send_banded(4'd10, dtm_pkg::KIND_OVERTEMP, V_UCR, 1'b0);
    send_banded(4'd11, dtm_pkg::KIND_FAN, V_LNC, 1'b0);
    send_banded(4'd11, dtm_pkg::KIND_FAN, V_LCR, 1'b1);

    // Random rounds, each under its own limits
    for (round = 0; round < RANDOM_ROUNDS; round++) begin
      drain();
      case (round)
        0: begin retry = 4'd1;  fan = 4'd1;  end
        1: begin retry = 4'd15; fan = 4'd15; end
        2: begin retry = 4'd0;  fan = 4'd0;  end
        3: begin retry = 4'd3;  fan = 4'd2;  end
        4: begin retry = 4'd15; fan = 4'd1;  end
        5: begin retry = 4'd2;  fan = 4'd15; end
        6: begin
          retry = dtm_pkg::RETRY_LIMIT_RESET;
          fan = dtm_pkg::FAN_FAIL_LIMIT_RESET;
        end
        default: begin
          retry = 4'($urandom_range(15, 1));
          fan = 4'($urandom_range(15, 1));
        end
      endcase
      set_limits(retry, fan);
      id_base = $urandom_range(NUM_SENSORS - 1, 0);
      for (int s = 0; s < NUM_SENSORS; s++) new_profile(s);
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        if (n % 40 == 0) quiet = ($urandom_range(3, 0) == 0);
        send_random_sample();
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dtm_pkg.sv
rtl/dtm_classify.sv
rtl/dtm_queue.sv
rtl/dtm_back.sv
rtl/debounced_threshold_monitor.sv
tb/sv/threshold_alarm_checker.sv
tb/sv/debounced_threshold_monitor_tb.sv
